// ===== hw/rtl/imu_pkg.sv =====
// Package for the invariant mass unit: field widths, root cell word type.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package imu_pkg;

	// width of one momentum component; every other width follows from it
	localparam int COMP_W = 16;
	localparam int EN_W   = COMP_W - 1;       // energy
	localparam int SQ_W   = 2 * COMP_W - 1;   // square of a component, unsigned
	localparam int ESQ_W  = 2 * EN_W;         // square of the energy
	localparam int MSQ_W  = 2 * COMP_W + 1;   // signed squared mass
	localparam int MASS_W = COMP_W - 1;       // floor root
	localparam int ROOT_W = 2 * COMP_W - 2;   // non-negative squared mass
	localparam int CELLS  = MASS_W;           // one root digit per cell

	// leading test bit of the digit-by-digit root: the highest even power below 2^ROOT_W
	localparam logic [ROOT_W-1:0] ROOT_BIT0 = ROOT_W'(1) << (2 * (MASS_W - 1));

	// word handed from cell to cell
	typedef struct packed {
		logic [ROOT_W-1:0]       rem;      // remainder still to resolve
		logic [ROOT_W-1:0]       root;     // partial root, scaled
		logic [ROOT_W-1:0]       tbit;     // current test bit
		logic signed [MSQ_W-1:0] msq;      // squared mass, carried along
		logic                    neg;      // squared mass below zero
	} root_word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/imu_if.sv =====
// Channel interfaces of the invariant mass unit: four-vector in, result out.
// Depends on imu_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface imu_vec_if;
	logic                              valid;
	logic                              ready;
	logic [imu_pkg::EN_W-1:0]          energy;
	logic signed [imu_pkg::COMP_W-1:0] mom_x;
	logic signed [imu_pkg::COMP_W-1:0] mom_y;
	logic signed [imu_pkg::COMP_W-1:0] mom_z;

	modport source (output valid, energy, mom_x, mom_y, mom_z, input ready);
	modport sink   (input valid, energy, mom_x, mom_y, mom_z, output ready);
endinterface

interface imu_res_if;
	logic                             valid;
	logic                             ready;
	logic signed [imu_pkg::MSQ_W-1:0] mass_squared;
	logic [imu_pkg::MASS_W-1:0]       mass;
	logic                             spacelike;

	modport source (output valid, mass_squared, mass, spacelike, input ready);
	modport sink   (input valid, mass_squared, mass, spacelike, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/imu_front.sv =====
// Front end: squares the four components and forms the signed squared mass
// over three stages. Depends on imu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imu_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              vec_valid,
	output      logic                              vec_ready,
	input  wire logic [imu_pkg::EN_W-1:0]          energy,
	input  wire logic signed [imu_pkg::COMP_W-1:0] mom_x,
	input  wire logic signed [imu_pkg::COMP_W-1:0] mom_y,
	input  wire logic signed [imu_pkg::COMP_W-1:0] mom_z,
	output      logic                              word_valid,
	input  wire logic                              word_ready,
	output      imu_pkg::root_word_t               word
);

	logic vld_s1, vld_s2, vld_s3;
	logic adv_s1, adv_s2, adv_s3;

	logic [imu_pkg::ESQ_W-1:0]        esq_s1;
	logic [imu_pkg::SQ_W-1:0]         xsq_s1, ysq_s1, zsq_s1;
	logic signed [imu_pkg::MSQ_W-1:0] part_a_s2;
	logic [imu_pkg::SQ_W:0]           part_b_s2;
	logic signed [imu_pkg::MSQ_W-1:0] msq_s3;

	logic signed [2*imu_pkg::COMP_W-1:0] xsq_full, ysq_full, zsq_full;

	// a stage takes a new word when it is empty or its word moves on
	assign adv_s3 = !vld_s3 || word_ready;
	assign adv_s2 = !vld_s2 || adv_s3;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign vec_ready = adv_s1;

	assign xsq_full = mom_x * mom_x;
	assign ysq_full = mom_y * mom_y;
	assign zsq_full = mom_z * mom_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= vec_valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			esq_s1 <= energy * energy;
			xsq_s1 <= xsq_full[imu_pkg::SQ_W-1:0];
			ysq_s1 <= ysq_full[imu_pkg::SQ_W-1:0];
			zsq_s1 <= zsq_full[imu_pkg::SQ_W-1:0];
		end
		if (adv_s2) begin
			part_a_s2 <= $signed(imu_pkg::MSQ_W'(esq_s1)) - $signed(imu_pkg::MSQ_W'(xsq_s1));
			part_b_s2 <= (imu_pkg::SQ_W+1)'(ysq_s1) + (imu_pkg::SQ_W+1)'(zsq_s1);
		end
		if (adv_s3) begin
			msq_s3 <= part_a_s2 - $signed(imu_pkg::MSQ_W'(part_b_s2));
		end
	end

	// a negative squared mass enters the root chain as zero
	always_comb begin
		word.msq  = msq_s3;
		word.neg  = msq_s3[imu_pkg::MSQ_W-1];
		word.rem  = word.neg ? '0 : msq_s3[imu_pkg::ROOT_W-1:0];
		word.root = '0;
		word.tbit = imu_pkg::ROOT_BIT0;
	end

	assign word_valid = vld_s3;

endmodule

`default_nettype wire

// ===== hw/rtl/imu_root_cell.sv =====
// One cell of the square-root chain: resolves one root digit and hands the
// word on. Depends on imu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imu_root_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                prev_valid,
	output      logic                prev_ready,
	input  wire imu_pkg::root_word_t prev_word,
	output      logic                next_valid,
	input  wire logic                next_ready,
	output      imu_pkg::root_word_t next_word
);

	logic                      vld_q;
	imu_pkg::root_word_t       word_q;
	imu_pkg::root_word_t       word_nx;
	logic [imu_pkg::ROOT_W:0]  trial;

	assign prev_ready = !vld_q || next_ready;

	// subtract root plus test bit when it fits, then shift root and test bit
	always_comb begin
		word_nx = prev_word;
		trial   = (imu_pkg::ROOT_W+1)'(prev_word.root) + (imu_pkg::ROOT_W+1)'(prev_word.tbit);
		if ((imu_pkg::ROOT_W+1)'(prev_word.rem) >= trial) begin
			word_nx.rem  = prev_word.rem - trial[imu_pkg::ROOT_W-1:0];
			word_nx.root = (prev_word.root >> 1) + prev_word.tbit;
		end else begin
			word_nx.root = prev_word.root >> 1;
		end
		word_nx.tbit = prev_word.tbit >> 2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (prev_ready) begin
			vld_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prev_ready) word_q <= word_nx;
	end

	assign next_valid = vld_q;
	assign next_word  = word_q;

endmodule

`default_nettype wire

// ===== hw/rtl/invariant_mass_unit_top.sv =====
// Top level of the invariant mass unit: front end and the square-root cell chain.
// Depends on imu_pkg, imu_if, imu_front and imu_root_cell.
//
//   channel  direction  handshake      word
//   vec      in         valid/ready    energy, mom_x, mom_y, mom_z
//   res      out        valid/ready    mass_squared, mass, spacelike
//
// One word enters every cycle while res does not stall; each result passes
// through three front stages, then one cell per root digit, the last cell
// register driving res.
// Reset clears only the valid flags; the data registers are not reset.
// A stall on res backs up stage by stage; an empty stage still takes a word.
`timescale 1ns / 1ps
`default_nettype none

module invariant_mass_unit_top (
	input wire logic clk,
	input wire logic arst_n,
	imu_vec_if.sink   vec,
	imu_res_if.source res
);

	// valid, ready and word at each joint of the cell chain
	logic                vld [imu_pkg::CELLS+1];
	logic                rdy [imu_pkg::CELLS+1];
	imu_pkg::root_word_t word[imu_pkg::CELLS+1];

	// square the components, form the squared mass
	imu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.vec_valid  (vec.valid),
		.vec_ready  (vec.ready),
		.energy     (vec.energy),
		.mom_x      (vec.mom_x),
		.mom_y      (vec.mom_y),
		.mom_z      (vec.mom_z),
		.word_valid (vld[0]),
		.word_ready (rdy[0]),
		.word       (word[0])
	);

	// one root digit per cell, most significant first
	for (genvar i = 0; i < imu_pkg::CELLS; i++) begin : g_cell
		imu_root_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.prev_valid (vld[i]),
			.prev_ready (rdy[i]),
			.prev_word  (word[i]),
			.next_valid (vld[i+1]),
			.next_ready (rdy[i+1]),
			.next_word  (word[i+1])
		);
	end

	// drive the result word straight from the last cell register
	assign rdy[imu_pkg::CELLS] = res.ready;
	assign res.valid           = vld[imu_pkg::CELLS];
	assign res.mass_squared    = word[imu_pkg::CELLS].msq;
	assign res.mass            = word[imu_pkg::CELLS].root[imu_pkg::MASS_W-1:0];
	assign res.spacelike       = word[imu_pkg::CELLS].neg;

	// root bounds, widened so the squares cannot wrap
	logic [imu_pkg::MSQ_W:0] mass_lo_sq, mass_hi_sq;
	assign mass_lo_sq = (imu_pkg::MSQ_W+1)'(res.mass) * (imu_pkg::MSQ_W+1)'(res.mass);
	assign mass_hi_sq = ((imu_pkg::MSQ_W+1)'(res.mass) + 1'b1)
		* ((imu_pkg::MSQ_W+1)'(res.mass) + 1'b1);

	a_flag_sign: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.spacelike == res.mass_squared[imu_pkg::MSQ_W-1])
		else $error("spacelike flag disagrees with sign of squared mass");

	a_neg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.spacelike |-> res.mass == '0)
		else $error("non-zero root for negative squared mass");

	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.spacelike |->
			mass_lo_sq <= (imu_pkg::MSQ_W+1)'(res.mass_squared)
			&& mass_hi_sq > (imu_pkg::MSQ_W+1)'(res.mass_squared))
		else $error("root is not the floor square root");

endmodule

`default_nettype wire

// ===== bench/tb_invariant_mass_unit_top.sv =====
// Self-checking bench for invariant_mass_unit_top: a directed table, then random four-vectors.
// Depends on imu_pkg, imu_if and the unit's RTL; every result is checked in order.
`timescale 1ns / 1ps

module tb_invariant_mass_unit_top;

	import imu_pkg::*;

	// one result word as the unit should give it
	typedef struct packed {
		logic signed [MSQ_W-1:0] msq;
		logic [MASS_W-1:0]       mass;
		logic                    spacelike;
	} mass_res_t;

	// one row of stimulus; typed-in results only where they are obvious
	typedef struct packed {
		logic [EN_W-1:0]          energy;
		logic signed [COMP_W-1:0] mom_x;
		logic signed [COMP_W-1:0] mom_y;
		logic signed [COMP_W-1:0] mom_z;
		logic                     has_gold;
		mass_res_t                gold;
	} vec_row_t;

	localparam int NDIR      = 19;
	localparam int NRAND     = 600;
	localparam int LATENCY   = 3 + MASS_W;
	localparam int HOLD_AT   = 100;   // word index at which the receiver holds off
	localparam int HOLD_LEN  = 150;   // cycles of that hold-off
	localparam int QUIET_LO  = 300;   // words in [QUIET_LO, QUIET_HI) go with no idling
	localparam int QUIET_HI  = 450;
	localparam int DRAIN_MAX = 4000;

	logic clk = 1'b0;
	logic arst_n;

	imu_vec_if vec_ch ();
	imu_res_if res_ch ();

	invariant_mass_unit_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vec    (vec_ch),
		.res    (res_ch)
	);

	always #1 clk = ~clk;

	// Directed table. Rows with has_gold set carry a result read straight off the formula;
	// the rest are checked against the predictor.
	vec_row_t dir_tab [NDIR] = '{
		// zero vector: lightlike, root 0
		'{15'd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{33'sd0, 15'd0, 1'b0}},
		// largest energy at rest: largest squared mass and root
		'{15'd32767, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{33'sd1073676289, 15'd32767, 1'b0}},
		// no energy, every component at its most negative: most negative squared mass
		'{15'd0, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1,
			'{-33'sd3221225472, 15'd0, 1'b1}},
		// no energy, every component at its most positive
		'{15'd0, 16'sd32767, 16'sd32767, 16'sd32767, 1'b1,
			'{-33'sd3221028867, 15'd0, 1'b1}},
		// lightlike 3-4-5, both signs
		'{15'd5, 16'sd3, 16'sd4, 16'sd0, 1'b1, '{33'sd0, 15'd0, 1'b0}},
		'{15'd5, -16'sd3, 16'sd0, -16'sd4, 1'b1, '{33'sd0, 15'd0, 1'b0}},
		// perfect square
		'{15'd10, 16'sd6, 16'sd0, 16'sd0, 1'b1, '{33'sd64, 15'd8, 1'b0}},
		// just below zero: spacelike by one
		'{15'd1, 16'sd1, 16'sd1, 16'sd0, 1'b1, '{-33'sd1, 15'd0, 1'b1}},
		// largest energy against the most negative component
		'{15'd32767, -16'sd32768, 16'sd0, 16'sd0, 1'b1, '{-33'sd65535, 15'd0, 1'b1}},
		// one below the largest square: root rounds down
		'{15'd32767, 16'sd1, 16'sd0, 16'sd0, 1'b1, '{33'sd1073676288, 15'd32766, 1'b0}},
		// small values, one non-square and one square: floor of the root
		'{15'd2, 16'sd1, 16'sd0, 16'sd0, 1'b1, '{33'sd3, 15'd1, 1'b0}},
		'{15'd3, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{33'sd9, 15'd3, 1'b0}},
		// the rest go through the predictor
		'{15'd32767, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0},
		'{15'd32767, 16'sd0, -16'sd1, 16'sd32767, 1'b0, '0},
		'{15'h2AAA, 16'sh5555, 16'shAAAA, 16'sh5555, 1'b0, '0},
		'{15'h5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 1'b0, '0},
		'{15'd12345, 16'sd100, -16'sd200, 16'sd300, 1'b0, '0},
		'{15'd32767, 16'sd18918, 16'sd18918, 16'sd18918, 1'b0, '0},
		'{15'd30000, -16'sd17320, -16'sd17320, -16'sd17321, 1'b0, '0}
	};

	vec_row_t  stim_q [$];
	mass_res_t expected_q [$];

	int stim_total = 0;
	int send_idx   = 0;    // next row to offer
	int cur_idx    = 0;    // row now on the input channel
	int acc_cnt    = 0;
	int res_cnt    = 0;
	int err_cnt    = 0;
	int neg_cnt    = 0;
	int light_cnt  = 0;
	int stall_cyc  = 0;
	logic vec_took = 1'b0;
	logic hold_on  = 1'b0;

	wire quiet = (send_idx >= QUIET_LO) && (send_idx < QUIET_HI);

	// floor square root by setting one bit at a time from the top
	function automatic longint floor_isqrt(longint n);
		longint r;
		longint t;
		r = 0;
		for (int b = 16; b >= 0; b--) begin
			t = r | (longint'(1) << b);
			if (t * t <= n)
				r = t;
		end
		return r;
	endfunction

	// squared invariant mass, its root and the spacelike flag for one four-vector
	function automatic mass_res_t predict_mass(logic [EN_W-1:0] e, logic signed [COMP_W-1:0] px,
		logic signed [COMP_W-1:0] py, logic signed [COMP_W-1:0] pz);
		mass_res_t r;
		longint    e2;
		longint    p2;
		longint    m2;
		e2 = longint'(e) * longint'(e);
		p2 = longint'(px) * longint'(px) + longint'(py) * longint'(py)
			+ longint'(pz) * longint'(pz);
		m2 = e2 - p2;
		r.msq       = m2[MSQ_W-1:0];
		r.spacelike = (m2 < 0);
		r.mass      = (m2 < 0) ? '0 : MASS_W'(floor_isqrt(m2));
		return r;
	endfunction

	// a component drawn mostly from its corner values
	function automatic logic signed [COMP_W-1:0] corner_comp();
		case ($urandom_range(0, 5))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'sd0;
			3: return 16'sd1;
			4: return -16'sd1;
			default: return COMP_W'($urandom);
		endcase
	endfunction

	task automatic note_mismatch(string what, longint got, longint want);
		err_cnt++;
		$display("MISMATCH at %0t ns: %s got %0d expected %0d", $time, what, got, want);
	endtask

	// Sender: offer rows in order, change only at the falling edge, idle now and then.
	// Never idle while the receiver holds off, so the pipeline fills and stalls the input.
	initial begin : sender
		vec_ch.valid  = 1'b0;
		vec_ch.energy = '0;
		vec_ch.mom_x  = '0;
		vec_ch.mom_y  = '0;
		vec_ch.mom_z  = '0;
		forever begin
			@(negedge clk);
			if (arst_n && (!vec_ch.valid || vec_took)) begin
				if (send_idx < stim_total && (quiet || hold_on || $urandom_range(0, 99) >= 25)) begin
					vec_ch.valid  <= 1'b1;
					vec_ch.energy <= stim_q[send_idx].energy;
					vec_ch.mom_x  <= stim_q[send_idx].mom_x;
					vec_ch.mom_y  <= stim_q[send_idx].mom_y;
					vec_ch.mom_z  <= stim_q[send_idx].mom_z;
					cur_idx       <= send_idx;
					send_idx      <= send_idx + 1;
				end else begin
					vec_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: drop ready at random, and once hold it low for a long count of cycles.
	initial begin : receiver
		int hold_left;
		bit hold_done;
		hold_left    = 0;
		hold_done    = 1'b0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (arst_n) begin
				if (!hold_done && send_idx >= HOLD_AT) begin
					hold_left = HOLD_LEN;
					hold_done = 1'b1;
				end
				if (hold_left > 0) begin
					hold_left--;
					hold_on      <= 1'b1;
					res_ch.ready <= 1'b0;
				end else begin
					hold_on      <= 1'b0;
					res_ch.ready <= quiet || ($urandom_range(0, 99) >= 25);
				end
			end
		end
	end

	// Monitor: check each result word against the oldest expectation, then log the
	// accepted input word. The unit registers every word before it reaches res, so the order is safe.
	always @(posedge clk) begin
		mass_res_t want;
		vec_took <= arst_n && vec_ch.valid && vec_ch.ready;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			res_cnt++;
			if (expected_q.size() == 0) begin
				note_mismatch("result word with nothing expected, mass_squared",
					longint'(res_ch.mass_squared), 0);
			end else begin
				want = expected_q.pop_front();
				if (res_ch.mass_squared !== want.msq)
					note_mismatch("mass_squared", longint'(res_ch.mass_squared),
						longint'(want.msq));
				if (res_ch.mass !== want.mass)
					note_mismatch("mass", longint'(res_ch.mass), longint'(want.mass));
				if (res_ch.spacelike !== want.spacelike)
					note_mismatch("spacelike", longint'(res_ch.spacelike),
						longint'(want.spacelike));
				if (want.spacelike)
					neg_cnt++;
				else if (want.msq == 0)
					light_cnt++;
			end
		end
		if (arst_n && vec_ch.valid && vec_ch.ready) begin
			acc_cnt++;
			if (stim_q[cur_idx].has_gold)
				expected_q.push_back(stim_q[cur_idx].gold);
			else
				expected_q.push_back(predict_mass(vec_ch.energy, vec_ch.mom_x,
					vec_ch.mom_y, vec_ch.mom_z));
		end
		if (arst_n && vec_ch.valid && !vec_ch.ready)
			stall_cyc++;
	end

	// Main sequence: build the stimulus, release reset, wait for the last word, report.
	initial begin : main
		vec_row_t row;
		int       mode;
		int       k;
		longint   p2;
		longint   e_l;
		int       drain;
		arst_n = 1'b0;

		foreach (dir_tab[i])
			stim_q.push_back(dir_tab[i]);

		for (int n = 0; n < NRAND; n++) begin
			row = '0;
			mode = $urandom_range(0, 4);
			case (mode)
				// any bit pattern
				0: begin
					row.energy = EN_W'($urandom);
					row.mom_x  = COMP_W'($urandom);
					row.mom_y  = COMP_W'($urandom);
					row.mom_z  = COMP_W'($urandom);
				end
				// timelike: big energy, modest momenta
				1: begin
					row.energy = EN_W'($urandom_range(16384, 32767));
					row.mom_x  = COMP_W'(int'($urandom_range(0, 16000)) - 8000);
					row.mom_y  = COMP_W'(int'($urandom_range(0, 16000)) - 8000);
					row.mom_z  = COMP_W'(int'($urandom_range(0, 16000)) - 8000);
				end
				// corners of every field
				2: begin
					row.energy = ($urandom_range(0, 2) == 0) ? 15'd32767 :
						($urandom_range(0, 1) ? 15'd0 : EN_W'($urandom));
					row.mom_x  = corner_comp();
					row.mom_y  = corner_comp();
					row.mom_z  = corner_comp();
				end
				// near the light cone: energy within one of the floor of the momentum length
				3: begin
					row.mom_x = COMP_W'(int'($urandom_range(0, 36000)) - 18000);
					row.mom_y = COMP_W'(int'($urandom_range(0, 36000)) - 18000);
					row.mom_z = COMP_W'(int'($urandom_range(0, 36000)) - 18000);
					p2 = longint'(row.mom_x) * row.mom_x + longint'(row.mom_y) * row.mom_y
						+ longint'(row.mom_z) * row.mom_z;
					e_l = floor_isqrt(p2) + longint'($urandom_range(0, 2)) - 1;
					if (e_l < 0)
						e_l = 0;
					row.energy = EN_W'(e_l);
				end
				// exactly lightlike, scaled 3-4-5 with random signs
				default: begin
					k = $urandom_range(0, 6553);
					row.energy = EN_W'(5 * k);
					row.mom_x  = COMP_W'($urandom_range(0, 1) ? 3 * k : -3 * k);
					row.mom_y  = COMP_W'($urandom_range(0, 1) ? 4 * k : -4 * k);
					row.mom_z  = 16'sd0;
					if ($urandom_range(0, 1)) begin
						row.mom_z = row.mom_y;
						row.mom_y = 16'sd0;
					end
				end
			endcase
			stim_q.push_back(row);
		end
		stim_total = stim_q.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (acc_cnt < stim_total)
			@(posedge clk);
		drain = 0;
		while (expected_q.size() != 0 && drain < DRAIN_MAX) begin
			@(posedge clk);
			drain++;
		end
		// let any stray word show up before the verdict
		repeat (LATENCY + 4) @(posedge clk);

		if (expected_q.size() != 0)
			note_mismatch("expected words left over", 0, expected_q.size());

		$display("Covered %0d four-vectors: %0d spacelike, %0d lightlike, %0d results checked.",
			acc_cnt, neg_cnt, light_cnt, res_cnt);
		$display("Input stalled by back-pressure for %0d cycles; %0d mismatches.",
			stall_cyc, err_cnt);
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run
	initial begin : watchdog
		#400000;
		$display("Timeout: run did not finish, %0d of %0d words accepted.", acc_cnt, stim_total);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/imu_pkg.sv
hw/rtl/imu_if.sv
hw/rtl/imu_front.sv
hw/rtl/imu_root_cell.sv
hw/rtl/invariant_mass_unit_top.sv
bench/tb_invariant_mass_unit_top.sv
